@@ hw/rtl/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, constants and address helpers for the text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

   localparam int COLUMNS   = 80;
   localparam int ROWS      = 25;
   localparam int CELLS     = ROWS * COLUMNS;
   localparam int ADDR_W    = $clog2(CELLS);

   localparam int ACTION_W  = 2;
   localparam int CHAR_W    = 8;
   localparam int ROW_W     = 5;
   localparam int COL_W     = 7;
   localparam int CELL_W    = 16;
   localparam int OFFSET_W  = 11;
   localparam int COLOR_W   = 4;
   localparam int ATTR_W    = 2 * COLOR_W;
   localparam int TAB_STEP  = 8;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);

   localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKGROUND = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FOREGROUND = 1'b1;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [CHAR_W-1:0]   character;
      logic [ROW_W-1:0]    read_row;
      logic [COL_W-1:0]    read_col;
   } req_item_type;

   typedef struct packed {
      logic [CELL_W-1:0]   cell_value;
      logic [COL_W-1:0]    cursor_col;
      logic [ROW_W-1:0]    cursor_row;
      logic [OFFSET_W-1:0] cursor_offset;
   } rsp_item_type;

   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             print;
      logic             scroll;
   } cursor_next_type;

   typedef struct packed {
      logic init_busy;
      logic item_busy;
   } ctrl_status_type;

   function automatic logic [ADDR_W-1:0] cell_index(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
      cell_index = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/tcw_screen_ram.sv @@
// ----------------------------------------------------------------------------
// tcw_screen_ram
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_screen_ram #(
   parameter int DEPTH = 2000,
   parameter int WIDTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ hw/rtl/tcw_cursor_step.sv @@
// ----------------------------------------------------------------------------
// tcw_cursor_step
// Next cursor position for a put: control bytes, wrap and scroll detection.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_cursor_step (
   input  wire logic [tcw_pkg::COL_W-1:0]  cur_col,
   input  wire logic [tcw_pkg::ROW_W-1:0]  cur_row,
   input  wire logic [tcw_pkg::CHAR_W-1:0] character,
   output tcw_pkg::cursor_next_type        next
);

   import tcw_pkg::*;

   logic [COL_W:0] col_x;
   logic [ROW_W:0] row_x;
   logic           print;

   always_comb begin
      col_x = {1'b0, cur_col};
      row_x = {1'b0, cur_row};
      print = 1'b0;
      case (character)
         CH_NEWLINE: begin
            col_x = '0;
            row_x = row_x + 1'b1;
         end
         CH_TAB: begin
            col_x = (col_x + (COL_W+1)'(TAB_STEP)) & ~((COL_W+1)'(TAB_STEP - 1));
         end
         CH_RETURN: begin
            col_x = '0;
         end
         CH_BACKSPACE: begin
            if (cur_col == '0) begin
               if (cur_row != '0) begin
                  row_x = row_x - 1'b1;
               end
               col_x = (COL_W+1)'(COLUMNS - 1);
            end else begin
               col_x = col_x - 1'b1;
            end
         end
         default: begin
            print = 1'b1;
            col_x = col_x + 1'b1;
         end
      endcase
      if (32'(col_x) >= COLUMNS) begin
         col_x = '0;
         row_x = row_x + 1'b1;
      end
      next.scroll = 1'b0;
      if (32'(row_x) >= ROWS) begin
         next.scroll = 1'b1;
         row_x = (ROW_W+1)'(ROWS - 1);
      end
      next.col   = col_x[COL_W-1:0];
      next.row   = row_x[ROW_W-1:0];
      next.print = print;
   end

endmodule

`default_nettype wire

@@ hw/rtl/tcw_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer around the screen RAM: put, read, clear, scroll copy and fills.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [tcw_pkg::ATTR_W-1:0] attr,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire tcw_pkg::req_item_type      req_item,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output tcw_pkg::rsp_item_type           rsp_item,
   output tcw_pkg::ctrl_status_type        status
);

   import tcw_pkg::*;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_SCROLL,
      ST_DRAIN,
      ST_FILL,
      ST_RESPOND
   } state_type;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic              copy_pend_ff, copy_pend_in;
   logic [ADDR_W-1:0] copy_addr_ff, copy_addr_in;
   logic [COL_W-1:0]  cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]  cur_row_ff, cur_row_in;
   logic [CELL_W-1:0] cell_ff, cell_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_item_ff, rsp_item_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [CELL_W-1:0] wr_data;
   logic [ADDR_W-1:0] rd_addr;
   logic [CELL_W-1:0] rd_data;
   logic [CELL_W-1:0] blank;
   cursor_next_type   nxt;

   tcw_screen_ram #(
      .DEPTH (CELLS),
      .WIDTH (CELL_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tcw_cursor_step u_cursor (
      .cur_col   (cur_col_ff),
      .cur_row   (cur_row_ff),
      .character (req_item.character),
      .next      (nxt)
   );

   assign blank = {attr, CH_SPACE};

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      copy_pend_in = copy_pend_ff;
      copy_addr_in = copy_addr_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      cell_in      = cell_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      wr_en        = 1'b0;
      wr_addr      = ptr_ff;
      wr_data      = blank;
      rd_addr      = ptr_ff;
      req_stall    = (state_ff != ST_IDLE);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_INIT: begin
            wr_en   = 1'b1;
            wr_data = '0;
            if (ptr_ff == LAST_ADDR) begin
               ptr_in   = '0;
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            rd_addr = cell_index(req_item.read_row, req_item.read_col);
            if (req_valid) begin
               cell_in = '0;
               case (req_item.action)
                  ACT_PUT: begin
                     cur_col_in = nxt.col;
                     cur_row_in = nxt.row;
                     if (nxt.print) begin
                        wr_en   = 1'b1;
                        wr_addr = cell_index(cur_row_ff, cur_col_ff);
                        wr_data = {attr, req_item.character};
                     end
                     if (nxt.scroll) begin
                        ptr_in   = ADDR_W'(COLUMNS);
                        state_in = ST_SCROLL;
                     end else begin
                        state_in = ST_RESPOND;
                     end
                  end
                  ACT_CLEAR: begin
                     cur_col_in = '0;
                     cur_row_in = '0;
                     ptr_in     = '0;
                     state_in   = ST_FILL;
                  end
                  ACT_READ: begin
                     if (32'(req_item.read_row) < ROWS && 32'(req_item.read_col) < COLUMNS) begin
                        state_in = ST_READ;
                     end else begin
                        state_in = ST_RESPOND;
                     end
                  end
                  default: begin
                     state_in = ST_RESPOND;
                  end
               endcase
            end
         end
         ST_READ: begin
            cell_in  = rd_data;
            state_in = ST_RESPOND;
         end
         ST_SCROLL: begin
            copy_pend_in = 1'b1;
            copy_addr_in = ptr_ff - ADDR_W'(COLUMNS);
            if (copy_pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = copy_addr_ff;
               wr_data = rd_data;
            end
            if (ptr_ff == LAST_ADDR) begin
               state_in = ST_DRAIN;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            wr_en        = 1'b1;
            wr_addr      = copy_addr_ff;
            wr_data      = rd_data;
            copy_pend_in = 1'b0;
            ptr_in       = ADDR_W'((ROWS - 1) * COLUMNS);
            state_in     = ST_FILL;
         end
         ST_FILL: begin
            wr_en = 1'b1;
            if (ptr_ff == LAST_ADDR) begin
               state_in = ST_RESPOND;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_RESPOND: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_item_in.cell_value    = cell_ff;
               rsp_item_in.cursor_col    = cur_col_ff;
               rsp_item_in.cursor_row    = cur_row_ff;
               rsp_item_in.cursor_offset = OFFSET_W'(cell_index(cur_row_ff, cur_col_ff));
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         ptr_ff       <= '0;
         copy_pend_ff <= 1'b0;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         copy_pend_ff <= copy_pend_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      copy_addr_ff <= copy_addr_in;
      cell_ff      <= cell_in;
      rsp_item_ff  <= rsp_item_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_item         = rsp_item_ff;
   assign status.init_busy = (state_ff == ST_INIT);
   assign status.item_busy = (state_ff != ST_INIT) && (state_ff != ST_IDLE);

endmodule

`default_nettype wire

@@ hw/rtl/text_console_writer_unit.sv @@
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Text console engine: 80x25 screen of attribute/character cells and a cursor.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one item per command (put character, clear screen, read cell).
//   rsp_*  : one item per command with cell word and cursor position/offset.
//   csr_*  : background/foreground color writes, always ready.
// Steps per item from acceptance to rsp_valid:
//   put without scroll : cursor step and cell write, next item accepted once back in idle
//   read               : RAM read, then cell register, then response register
//   put with scroll    : copy of ROWS-1 rows up through the RAM's one read
//                        and one write port, then blank bottom row
//   clear              : all ROWS*COLUMNS cells blanked (one cell written per cycle)
// Reset: cursor homes, colors clear, and the screen RAM is swept to zero
//   while req_stall stays high; csr writes are taken.
// A stalled result sits in the output register; one more item is accepted and
//   processed meanwhile, and waits until the register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire tcw_pkg::req_item_type         req_item,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output tcw_pkg::rsp_item_type              rsp_item,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [tcw_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [tcw_pkg::COLOR_W-1:0]   csr_data
);

   import tcw_pkg::*;

   logic [COLOR_W-1:0] bg_color_ff, bg_color_in;
   logic [COLOR_W-1:0] fg_color_ff, fg_color_in;
   ctrl_status_type    status;

   assign csr_ready = 1'b1;

   always_comb begin
      bg_color_in = bg_color_ff;
      fg_color_in = fg_color_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BACKGROUND: bg_color_in = csr_data;
            CSR_FOREGROUND: fg_color_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bg_color_ff <= '0;
         fg_color_ff <= '0;
      end else begin
         bg_color_ff <= bg_color_in;
         fg_color_ff <= fg_color_in;
      end
   end

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .attr      ({bg_color_ff, fg_color_ff}),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .status    (status)
   );

`ifndef SYNTHESIS
   a_init_stalls: assert property (@(posedge clock) disable iff (reset)
      status.init_busy |-> req_stall)
      else $error("item accepted during screen init");

   a_init_no_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(status.init_busy) |-> !rsp_valid)
      else $error("result produced before screen init finished");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> status.item_busy)
      else $error("accepted item not processed");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_item.cursor_col) < COLUMNS && 32'(rsp_item.cursor_row) < ROWS))
      else $error("cursor out of range in result");
`endif

endmodule

`default_nettype wire

@@ sim/text_console_writer_unit_tb.sv @@
// ----------------------------------------------------------------------------
// text_console_writer_unit_tb
// Self-checking bench for the text console writer. A queue of commands feeds a
// clocked driver. A shadow screen and cursor predict each response, and a
// clocked monitor compares the responses field by field. The run covers
// directed edge cases, then random text, control bytes, reads, clears and
// scrolls under random idling, under a long response hold and under several
// color settings.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_unit_tb;
   import tcw_pkg::*;

   localparam int CYCLE_LIMIT = 8_000_000;
   localparam int LONG_HOLD   = 300;
   localparam int MAX_REPORTS = 10;
   localparam int REQ_W       = $bits(req_item_type);

   localparam logic [ACTION_W-1:0] ACT_NOP = 2'd3;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_item_type         req_item = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_item_type         rsp_item;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [COLOR_W-1:0]   csr_data = '0;

   text_console_writer_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // shadow of the screen, cursor and colors
   logic [CELL_W-1:0]  shadow_screen [CELLS];
   int unsigned        shadow_col;
   int unsigned        shadow_row;
   logic [COLOR_W-1:0] bg_shadow;
   logic [COLOR_W-1:0] fg_shadow;

   req_item_type cmd_queue[$];
   rsp_item_type pending_results[$];
   rsp_item_type oldest_result;
   int           queued_total = 0;
   int           fault_count = 0;
   int           cycle_count = 0;
   logic         req_fired = 1'b0;
   logic         calm = 1'b0;
   logic         long_hold_go = 1'b0;
   logic         long_hold_done = 1'b0;
   int           hold_cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic rsp_item_type next_console_result(input req_item_type cmd);
      rsp_item_type     r;
      logic [ATTR_W-1:0] attr;
      logic [CELL_W-1:0] blank;
      int unsigned      i;
      attr  = {bg_shadow, fg_shadow};
      blank = {attr, CH_SPACE};
      r = '0;
      case (cmd.action)
         ACT_PUT: begin
            case (cmd.character)
               CH_NEWLINE: begin
                  shadow_col = 0;
                  shadow_row++;
               end
               CH_TAB: shadow_col = (shadow_col + TAB_STEP) & ~(TAB_STEP - 1);
               CH_RETURN: shadow_col = 0;
               CH_BACKSPACE: begin
                  if (shadow_col == 0) begin
                     if (shadow_row > 0) shadow_row--;
                     shadow_col = COLUMNS - 1;
                  end else begin
                     shadow_col--;
                  end
               end
               default: begin
                  if (shadow_row < ROWS && shadow_col < COLUMNS)
                     shadow_screen[ADDR_W'(shadow_row * COLUMNS + shadow_col)] =
                        {attr, cmd.character};
                  shadow_col++;
               end
            endcase
            if (shadow_col >= COLUMNS) begin
               shadow_col = 0;
               shadow_row++;
            end
            while (shadow_row >= ROWS) begin
               for (i = 0; i < (ROWS - 1) * COLUMNS; i++)
                  shadow_screen[ADDR_W'(i)] = shadow_screen[ADDR_W'(i + COLUMNS)];
               for (i = (ROWS - 1) * COLUMNS; i < CELLS; i++)
                  shadow_screen[ADDR_W'(i)] = blank;
               shadow_row--;
            end
         end
         ACT_CLEAR: begin
            for (i = 0; i < CELLS; i++)
               shadow_screen[ADDR_W'(i)] = blank;
            shadow_col = 0;
            shadow_row = 0;
         end
         ACT_READ: begin
            if (cmd.read_row < ROWS && cmd.read_col < COLUMNS)
               r.cell_value = shadow_screen[ADDR_W'(cmd.read_row * COLUMNS + cmd.read_col)];
         end
         default: ;
      endcase
      r.cursor_col    = COL_W'(shadow_col);
      r.cursor_row    = ROW_W'(shadow_row);
      r.cursor_offset = OFFSET_W'(shadow_row * COLUMNS + shadow_col);
      return r;
   endfunction

   function automatic string rsp_text(input rsp_item_type r);
      return $sformatf("cell=%04h col=%0d row=%0d offset=%0d",
                       r.cell_value, r.cursor_col, r.cursor_row, r.cursor_offset);
   endfunction

   function automatic void flag_fault(input string what);
      fault_count++;
      if (fault_count <= MAX_REPORTS)
         $display("ERROR cycle %0d: %s", cycle_count, what);
   endfunction

   function automatic req_item_type make_cmd(input logic [ACTION_W-1:0] act,
                                             input logic [CHAR_W-1:0] ch,
                                             input logic [ROW_W-1:0] row,
                                             input logic [COL_W-1:0] col);
      req_item_type c;
      c.action    = act;
      c.character = ch;
      c.read_row  = row;
      c.read_col  = col;
      return c;
   endfunction

   function automatic void push_cmd(input req_item_type c);
      cmd_queue.push_back(c);
      if (c.action != ACT_NOP) queued_total++;
   endfunction

   function automatic void push_put(input logic [CHAR_W-1:0] ch);
      push_cmd(make_cmd(ACT_PUT, ch, ROW_W'($urandom_range(31)), COL_W'($urandom_range(127))));
   endfunction

   function automatic void push_read(input int row, input int col);
      push_cmd(make_cmd(ACT_READ, CHAR_W'($urandom_range(255)), ROW_W'(row), COL_W'(col)));
   endfunction

   function automatic logic [CHAR_W-1:0] text_byte();
      if ($urandom_range(99) < 85) return CHAR_W'($urandom_range(32, 126));
      return CHAR_W'($urandom_range(255));
   endfunction

   function automatic logic [CHAR_W-1:0] control_byte();
      case ($urandom_range(5))
         0, 1:    return CH_BACKSPACE;
         2:       return CH_TAB;
         3:       return CH_RETURN;
         default: return CH_NEWLINE;
      endcase
   endfunction

   task automatic queue_random_items(input int count);
      int start;
      int pick;
      int len;
      int k;
      start = queued_total;
      while (queued_total - start < count) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(60, 100) : $urandom_range(1, 24);
            for (k = 0; k < len; k++) push_put(text_byte());
            case ($urandom_range(3))
               0: push_put(CH_NEWLINE);
               1: begin
                  push_put(CH_RETURN);
                  push_put(CH_NEWLINE);
               end
               2: push_put(CH_RETURN);
               default: ;
            endcase
         end else if (pick < 60) begin
            len = $urandom_range(1, 6);
            for (k = 0; k < len; k++)
               push_read(($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(ROWS - 1),
                         ($urandom_range(9) == 0) ? $urandom_range(127)
                                                  : $urandom_range(COLUMNS - 1));
         end else if (pick < 75) begin
            len = $urandom_range(1, 8);
            for (k = 0; k < len; k++) push_put(control_byte());
         end else if (pick < 85) begin
            len = $urandom_range(1, 4);
            for (k = 0; k < len; k++) push_cmd(req_item_type'(REQ_W'($urandom())));
         end else if (pick < 90) begin
            len = $urandom_range(5, 30);
            for (k = 0; k < len; k++) push_put(CH_NEWLINE);
         end else if (pick < 94) begin
            push_cmd(make_cmd(ACT_CLEAR, CHAR_W'($urandom_range(255)),
                              ROW_W'($urandom_range(31)), COL_W'($urandom_range(127))));
         end else begin
            push_cmd(make_cmd(ACT_NOP, CHAR_W'($urandom_range(255)),
                              ROW_W'($urandom_range(31)), COL_W'($urandom_range(127))));
         end
      end
   endtask

   task automatic write_color(input logic [CSR_IDX_W-1:0] idx, input logic [COLOR_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_BACKGROUND) bg_shadow = val;
      else fg_shadow = val;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_all_done();
      while (cmd_queue.size() != 0 || req_valid || pending_results.size() != 0)
         @(posedge clock);
   endtask

   // driver: hold a stalled item, advance on acceptance, idle at random
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (cmd_queue.size() != 0 && (calm || $urandom_range(99) >= 36)) begin
            req_valid <= 1'b1;
            req_item  <= cmd_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      req_fired <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall)
         pending_results.push_back(next_console_result(req_item));
   end

   // receiver stall: random, calm, or one long hold
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (long_hold_go && !long_hold_done) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles + 1;
         if (hold_cycles == LONG_HOLD) long_hold_done <= 1'b1;
      end else if (calm) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < 36);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            flag_fault({"response with no command pending: ", rsp_text(rsp_item)});
         end else begin
            oldest_result = pending_results.pop_front();
            if (rsp_item.cell_value !== oldest_result.cell_value
                || rsp_item.cursor_col !== oldest_result.cursor_col
                || rsp_item.cursor_row !== oldest_result.cursor_row
                || rsp_item.cursor_offset !== oldest_result.cursor_offset)
               flag_fault({"mismatch: expected ", rsp_text(oldest_result),
                           " got ", rsp_text(rsp_item)});
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < CELLS; i++) shadow_screen[ADDR_W'(i)] = '0;
      shadow_col = 0;
      shadow_row = 0;
      bg_shadow  = '0;
      fg_shadow  = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_color(CSR_BACKGROUND, 4'hF);
      write_color(CSR_FOREGROUND, 4'h0);

      // directed: reads of the swept store, edge cursor moves, wraps, clear
      push_read(0, 0);
      push_read(ROWS - 1, COLUMNS - 1);
      push_read(31, 127);
      push_read(ROWS, 5);
      push_read(3, COLUMNS);
      push_put(8'h41);
      push_put(8'h00);
      push_put(8'hFF);
      push_put(CH_BACKSPACE);
      push_put(CH_RETURN);
      push_put(CH_BACKSPACE);
      push_put(8'h7E);
      push_put(CH_BACKSPACE);
      push_put(CH_TAB);
      push_put(CH_TAB);
      push_put(CH_NEWLINE);
      push_cmd(make_cmd(ACT_NOP, 8'hA5, 5'd31, 7'd127));
      push_read(0, COLUMNS - 1);
      push_read(0, 1);
      push_cmd(make_cmd(ACT_CLEAR, 8'h00, 5'd0, 7'd0));
      push_read(ROWS - 1, COLUMNS - 1);
      push_put(8'h80);
      push_read(0, 0);
      wait_all_done();

      write_color(CSR_BACKGROUND, 4'h0);
      write_color(CSR_FOREGROUND, 4'hF);
      calm = 1'b1;
      for (int k = 0; k < ROWS + 3; k++) push_put(CH_NEWLINE);
      for (int k = 0; k < COLUMNS + 2; k++) push_put(text_byte());
      push_read(ROWS - 2, COLUMNS - 1);
      push_read(ROWS - 1, 0);
      push_read(ROWS - 1, 1);
      queue_random_items(200);
      wait_all_done();
      calm = 1'b0;

      write_color(CSR_BACKGROUND, COLOR_W'($urandom_range(15)));
      write_color(CSR_FOREGROUND, COLOR_W'($urandom_range(15)));
      long_hold_go = 1'b1;
      queue_random_items(220);
      wait_all_done();

      write_color(CSR_BACKGROUND, 4'hF);
      write_color(CSR_FOREGROUND, 4'hF);
      queue_random_items(220);
      wait_all_done();

      repeat (CELLS + 100) @(posedge clock);
      if (fault_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
